@@ sv/cau_pkg.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared constants, command codes, stage record types and small helpers.
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD        = 14;

    // Divider: 32-bit divisor, 48-bit numerator magnitude, 25 quotient bits.
    localparam int DW   = 32;
    localparam int NW   = 48;
    localparam int QW   = 25;
    localparam int RW   = DW + QW + 1;
    localparam int NSTG = QW + 1;

    // CORDIC datapath widths.
    localparam int XW = 34;
    localparam int ZW = 28;
    localparam int VW = 34;

    localparam logic [29:0] KINV_Q30 = 30'd652032874;
    localparam logic [14:0] KINV_HI  = KINV_Q30[29:15];
    localparam logic [14:0] KINV_LO  = KINV_Q30[14:0];

    localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;

    localparam logic signed [VW-1:0] SAT_MAX = 34'sd8388607;
    localparam logic signed [VW-1:0] SAT_MIN = -34'sd8388608;
    localparam logic signed [VW-1:0] OVR_POS = 34'sd8388608;
    localparam logic signed [VW-1:0] OVR_NEG = -34'sd8388609;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_RECIP = 3'd3,
        CMD_DIV   = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_PHASE = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [15:0] ar;
        logic signed [15:0] ai;
        logic signed [15:0] br;
        logic signed [15:0] bi;
    } in_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [15:0] ar;
        logic signed [15:0] ai;
        logic signed [15:0] br;
        logic signed [15:0] bi;
        logic signed [31:0] p_rr;
        logic signed [31:0] p_ii;
        logic signed [31:0] p_ri;
        logic signed [31:0] p_ir;
        logic signed [31:0] p_aa;
        logic signed [31:0] p_a2;
        logic signed [31:0] p_bb;
        logic signed [31:0] p_b2;
    } prod_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [VW-1:0] dir_re;
        logic signed [VW-1:0] dir_im;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic               rot;
        logic [DW-1:0]      d;
        logic [RW-1:0]      rem_re;
        logic [RW-1:0]      rem_im;
        logic [QW-1:0]      q_re;
        logic [QW-1:0]      q_im;
        logic               neg_re;
        logic               neg_im;
        logic               big_re;
        logic               big_im;
        logic               dz;
    } it_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [VW-1:0] dir_re;
        logic signed [VW-1:0] dir_im;
        logic signed [49:0] pm_hi;
        logic signed [49:0] pm_lo;
        logic signed [ZW-1:0] ph;
        logic signed [QW:0] qs_re;
        logic signed [QW:0] qs_im;
        logic               neg_re;
        logic               neg_im;
        logic               big_re;
        logic               big_im;
        logic               dz;
    } mo_t;

    // Arctangent of 2^-i in Q24 radians.
    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VW-1:0] abs_v(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] n;
        n = -v;
        return v[VW-1] ? VW'(unsigned'(n)) : VW'(unsigned'(v));
    endfunction

    function automatic logic sat_ov(input logic signed [VW-1:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] s;
        if (v > SAT_MAX)
        begin
            s = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            s = SAT_MIN;
        end
        else
        begin
            s = v;
        end
        return s[23:0];
    endfunction

endpackage

@@ sv/complex_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined fixed-point complex add, subtract, multiply, reciprocal, divide,
// magnitude and phase with 24-bit saturated results.
// ---------------------------------------------------------------------------
// The unit accepts one item per clock while the output is not stalled and
// returns one result per item, in order. The divider resolves one quotient
// bit per stage over 25 stages after a range check; the CORDIC stages run
// alongside it in the same pipeline. The whole pipeline advances whenever
// the output register is empty or being taken, so a stalled result holds
// every item in place without loss. Command 7 returns zero with both flags
// clear. A zero divisor returns zero and sets div_by_zero.
module complex_arithmetic_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_real[15:0], a_imag[31:16], b_real[47:32], b_imag[63:48]
    input  logic [63:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_real[23:0], res_imag[47:24]
    output logic [47:0] m_axis_tdata,
    // overflow[0], div_by_zero[1]
    output logic [1:0]  m_axis_tuser
);
    import cau_pkg::*;

    logic  en;

    in_t   in_reg;
    logic  in_valid_reg;
    prod_t pr_reg;
    prod_t pr_next;
    logic  pr_valid_reg;
    it_t   it_reg [0:NSTG];
    it_t   it_next [0:NSTG];
    logic  it_valid_reg [0:NSTG];
    mo_t   mo_reg;
    mo_t   mo_next;
    logic  mo_valid_reg;

    logic [47:0] out_data_reg;
    logic [47:0] out_data_next;
    logic [1:0]  out_user_reg;
    logic [1:0]  out_user_next;
    logic        out_valid_reg;
    cmd_t        out_cmd_reg;

    // The pipeline moves as a whole when the output can take a new item.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Each stage after stage zero resolves one divider bit; the first CORDIC_STEPS
    // stages each do one CORDIC rotation. Stage zero checks for a quotient over 25 bits.
    function automatic it_t it_step(input it_t r, input int j);
        it_t o;
        logic [RW-1:0] dsh;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        o = r;
        if (j == 0)
        begin
            dsh = RW'(r.d) << QW;
            o.big_re = r.rem_re >= dsh;
            o.big_im = r.rem_im >= dsh;
        end
        else
        begin
            dsh = RW'(r.d) << (QW - j);
            if (r.rem_re >= dsh)
            begin
                o.rem_re = r.rem_re - dsh;
                o.q_re   = r.q_re | (QW'(1) << (QW - j));
            end
            if (r.rem_im >= dsh)
            begin
                o.rem_im = r.rem_im - dsh;
                o.q_im   = r.q_im | (QW'(1) << (QW - j));
            end
        end
        if (j < CORDIC_STEPS && r.rot)
        begin
            dx = r.y >>> j;
            dy = r.x >>> j;
            if (!r.y[XW-1])
            begin
                o.x = r.x + dx;
                o.y = r.y - dy;
                o.z = r.z + atan_q24(j);
            end
            else
            begin
                o.x = r.x - dx;
                o.y = r.y + dy;
                o.z = r.z - atan_q24(j);
            end
        end
        return o;
    endfunction

    // Stage one: all partial products.
    always_comb
    begin
        pr_next.cmd  = in_reg.cmd;
        pr_next.ar   = in_reg.ar;
        pr_next.ai   = in_reg.ai;
        pr_next.br   = in_reg.br;
        pr_next.bi   = in_reg.bi;
        pr_next.p_rr = 32'(in_reg.ar) * 32'(in_reg.br);
        pr_next.p_ii = 32'(in_reg.ai) * 32'(in_reg.bi);
        pr_next.p_ri = 32'(in_reg.ar) * 32'(in_reg.bi);
        pr_next.p_ir = 32'(in_reg.ai) * 32'(in_reg.br);
        pr_next.p_aa = 32'(in_reg.ar) * 32'(in_reg.ar);
        pr_next.p_a2 = 32'(in_reg.ai) * 32'(in_reg.ai);
        pr_next.p_bb = 32'(in_reg.br) * 32'(in_reg.br);
        pr_next.p_b2 = 32'(in_reg.bi) * 32'(in_reg.bi);
    end

    // Stage two: sums, divider numerators and CORDIC start vectors.
    always_comb
    begin
        logic signed [VW-1:0] ar_w;
        logic signed [VW-1:0] ai_w;
        logic signed [VW-1:0] nr;
        logic signed [VW-1:0] ni;
        logic signed [XW-1:0] axr;
        logic signed [XW-1:0] axi;
        logic signed [XW-1:0] sar;
        logic signed [XW-1:0] sai;
        ar_w = VW'(pr_reg.ar);
        ai_w = VW'(pr_reg.ai);
        nr   = VW'(pr_reg.p_rr) + VW'(pr_reg.p_ii);
        ni   = VW'(pr_reg.p_ir) - VW'(pr_reg.p_ri);
        axr  = signed'(XW'(abs_v(ar_w))) <<< GUARD;
        axi  = signed'(XW'(abs_v(ai_w))) <<< GUARD;
        sar  = XW'(pr_reg.ar) <<< GUARD;
        sai  = XW'(pr_reg.ai) <<< GUARD;

        it_next[0]        = '0;
        it_next[0].cmd    = pr_reg.cmd;
        it_next[0].dir_re = '0;
        it_next[0].dir_im = '0;

        unique case (pr_reg.cmd)
            CMD_ADD:
            begin
                it_next[0].dir_re = ar_w + VW'(pr_reg.br);
                it_next[0].dir_im = ai_w + VW'(pr_reg.bi);
            end
            CMD_SUB:
            begin
                it_next[0].dir_re = ar_w - VW'(pr_reg.br);
                it_next[0].dir_im = ai_w - VW'(pr_reg.bi);
            end
            CMD_MUL:
            begin
                it_next[0].dir_re = (VW'(pr_reg.p_rr) - VW'(pr_reg.p_ii)) >>> FRAC_BITS;
                it_next[0].dir_im = (VW'(pr_reg.p_ri) + VW'(pr_reg.p_ir)) >>> FRAC_BITS;
            end
            CMD_RECIP:
            begin
                it_next[0].d      = DW'(unsigned'(pr_reg.p_aa)) + DW'(unsigned'(pr_reg.p_a2));
                it_next[0].rem_re = RW'(NW'(abs_v(ar_w)) << (2 * FRAC_BITS));
                it_next[0].rem_im = RW'(NW'(abs_v(ai_w)) << (2 * FRAC_BITS));
                it_next[0].neg_re = pr_reg.ar < 0;
                it_next[0].neg_im = pr_reg.ai > 0;
            end
            CMD_DIV:
            begin
                it_next[0].d      = DW'(unsigned'(pr_reg.p_bb)) + DW'(unsigned'(pr_reg.p_b2));
                it_next[0].rem_re = RW'(NW'(abs_v(nr)) << FRAC_BITS);
                it_next[0].rem_im = RW'(NW'(abs_v(ni)) << FRAC_BITS);
                it_next[0].neg_re = nr < 0;
                it_next[0].neg_im = ni < 0;
            end
            CMD_MAG:
            begin
                it_next[0].x   = axr;
                it_next[0].y   = axi;
                it_next[0].rot = 1'b1;
            end
            CMD_PHASE:
            begin
                // Points off the right half plane are turned by a quarter turn
                // first; the imaginary and negative real axes get their angle directly.
                if (pr_reg.ar == 0)
                begin
                    if (pr_reg.ai > 0)
                    begin
                        it_next[0].z = HALF_PI_Q24;
                    end
                    else if (pr_reg.ai < 0)
                    begin
                        it_next[0].z = -HALF_PI_Q24;
                    end
                end
                else if (pr_reg.ar > 0)
                begin
                    it_next[0].x   = sar;
                    it_next[0].y   = sai;
                    it_next[0].rot = 1'b1;
                end
                else if (pr_reg.ai == 0)
                begin
                    it_next[0].z = HALF_PI_Q24 <<< 1;
                end
                else if (pr_reg.ai > 0)
                begin
                    it_next[0].x   = sai;
                    it_next[0].y   = -sar;
                    it_next[0].z   = HALF_PI_Q24;
                    it_next[0].rot = 1'b1;
                end
                else
                begin
                    it_next[0].x   = -sai;
                    it_next[0].y   = sar;
                    it_next[0].z   = -HALF_PI_Q24;
                    it_next[0].rot = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    for (genvar j = 0; j < NSTG; j++)
    begin : g_iter
        assign it_next[j+1] = it_step(it_reg[j], j);
    end

    // Gain correction split in two narrow products, phase rounding, signs.
    always_comb
    begin
        it_t r;
        logic signed [QW:0] qr;
        logic signed [QW:0] qi;
        r  = it_reg[NSTG];
        qr = signed'((QW + 1)'(r.q_re));
        qi = signed'((QW + 1)'(r.q_im));
        mo_next.cmd    = r.cmd;
        mo_next.dir_re = r.dir_re;
        mo_next.dir_im = r.dir_im;
        mo_next.pm_hi  = 50'(r.x) * 50'(signed'({1'b0, KINV_HI}));
        mo_next.pm_lo  = 50'(r.x) * 50'(signed'({1'b0, KINV_LO}));
        mo_next.ph     = (r.z + (ZW'(1) <<< (23 - FRAC_BITS))) >>> (24 - FRAC_BITS);
        mo_next.qs_re  = r.neg_re ? -qr : qr;
        mo_next.qs_im  = r.neg_im ? -qi : qi;
        mo_next.neg_re = r.neg_re;
        mo_next.neg_im = r.neg_im;
        mo_next.big_re = r.big_re;
        mo_next.big_im = r.big_im;
        mo_next.dz     = r.d == 0;
    end

    // Final stage: select, saturate and pack.
    always_comb
    begin
        logic signed [65:0]   magv;
        logic signed [VW-1:0] vre;
        logic signed [VW-1:0] vim;
        logic                 dz;
        magv = ((66'(mo_reg.pm_hi) <<< 15) + 66'(mo_reg.pm_lo) + (66'sd1 <<< 43)) >>> 44;
        vre  = '0;
        vim  = '0;
        dz   = 1'b0;
        unique case (mo_reg.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL:
            begin
                vre = mo_reg.dir_re;
                vim = mo_reg.dir_im;
            end
            CMD_RECIP, CMD_DIV:
            begin
                if (mo_reg.dz)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    vre = mo_reg.big_re ? (mo_reg.neg_re ? OVR_NEG : OVR_POS)
                                        : VW'(mo_reg.qs_re);
                    vim = mo_reg.big_im ? (mo_reg.neg_im ? OVR_NEG : OVR_POS)
                                        : VW'(mo_reg.qs_im);
                end
            end
            CMD_MAG:
            begin
                vre = VW'(magv);
            end
            CMD_PHASE:
            begin
                vre = VW'(mo_reg.ph);
            end
            default:
            begin
            end
        endcase
        out_data_next = {sat24(vim), sat24(vre)};
        out_user_next = {dz, sat_ov(vre) || sat_ov(vim)};
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            mo_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NSTG; k++)
            begin
                it_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            in_valid_reg    <= s_axis_tvalid;
            pr_valid_reg    <= in_valid_reg;
            it_valid_reg[0] <= pr_valid_reg;
            for (int k = 1; k <= NSTG; k++)
            begin
                it_valid_reg[k] <= it_valid_reg[k-1];
            end
            mo_valid_reg    <= it_valid_reg[NSTG];
            out_valid_reg   <= mo_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg.cmd   <= cmd_t'(s_axis_tuser);
            in_reg.ar    <= s_axis_tdata[15:0];
            in_reg.ai    <= s_axis_tdata[31:16];
            in_reg.br    <= s_axis_tdata[47:32];
            in_reg.bi    <= s_axis_tdata[63:48];
            pr_reg       <= pr_next;
            for (int k = 0; k <= NSTG; k++)
            begin
                it_reg[k] <= it_next[k];
            end
            mo_reg       <= mo_next;
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_cmd_reg  <= mo_reg.cmd;
        end
    end

    // A zero divisor always returns a zero result.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 48'd0)
        else $error("div_by_zero result is not zero");

    // Overflow and divide-by-zero never come together.
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("overflow and div_by_zero both set");

    // Magnitude and phase leave the imaginary part at zero.
    a_scalar_imag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_cmd_reg == CMD_MAG || out_cmd_reg == CMD_PHASE)
        |-> m_axis_tdata[47:24] == 24'd0)
        else $error("scalar result has nonzero imaginary part");

endmodule
